// ===== hdl/spq_pkg.sv =====
package spq_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LIST   = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int MAX_RESULTS = 16;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] entry_value;
      logic [4:0]         position;
      logic [4:0]         entry_count;
      logic               is_last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      DP_HOLD,
      DP_INSERT,
      DP_POP,
      DP_ROTATE
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic signed [31:0] value;
   } dp_cmd_type;

endpackage

// ===== hdl/spq_datapath.sv =====
module spq_datapath #(
   parameter int CAPACITY = 16,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  spq_pkg::dp_cmd_type cmd,
   output logic [CW-1:0]       count,
   output logic signed [31:0]  head
);
   import spq_pkg::*;

   logic signed [31:0] entries_ff [CAPACITY];
   logic signed [31:0] entries_in [CAPACITY];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [CAPACITY-1:0] after;

   // after[i]: entry i sits at or behind the insert point
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            after[i] = (count_ff == '0) || (cmd.value < entries_ff[0]);
         end else begin
            after[i] = (CW'(i) >= count_ff) || (entries_ff[i] >= cmd.value);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
      end
      case (cmd.op)
         DP_INSERT: begin
            count_in = count_ff + CW'(1);
            for (int i = 0; i < CAPACITY; i++) begin
               if (!after[i]) begin
                  entries_in[i] = entries_ff[i];
               end else if (i == 0) begin
                  entries_in[i] = cmd.value;
               end else if (!after[i-1]) begin
                  entries_in[i] = cmd.value;
               end else begin
                  entries_in[i] = entries_ff[i-1];
               end
            end
         end
         DP_POP: begin
            count_in = count_ff - CW'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
               entries_in[i] = entries_ff[i+1];
            end
         end
         DP_ROTATE: begin
            for (int i = 0; i < CAPACITY; i++) begin
               if ((CW'(i) == count_ff - CW'(1)) || (i == CAPACITY - 1)) begin
                  entries_in[i] = entries_ff[0];
               end else begin
                  entries_in[i] = entries_ff[(i + 1) % CAPACITY];
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   assign count = count_ff;
   assign head  = entries_ff[0];

endmodule

// ===== hdl/spq_control.sv =====
module spq_control #(
   parameter int CAPACITY = 16,
   parameter int CW       = $clog2(CAPACITY + 1),
   parameter int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word,
   output spq_pkg::dp_cmd_type   cmd,
   input  logic [CW-1:0]         count,
   input  logic signed [31:0]    head
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HOLD,
      S_LIST
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   req_word_type  held_ff, held_in;
   logic [IW-1:0] idx_ff, idx_in;
   rsp_word_type  rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          out_free;
   logic          accept;
   logic          go;
   req_word_type  item;
   logic          emitting;
   logic [31:0]   emit_total;
   logic [31:0]   pos_next;
   logic [31:0]   cnt_inc;
   logic [31:0]   cnt_dec;
   logic          load;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign item       = (state_ff == S_IDLE) ? req_word : held_ff;
   assign go         = ((state_ff == S_IDLE) && accept && out_free)
                    || ((state_ff == S_HOLD) && out_free);
   assign emitting   = (32'(idx_ff) < 32'(MAX_RESULTS));
   assign emit_total = (32'(count) > 32'(MAX_RESULTS)) ? 32'(MAX_RESULTS) : 32'(count);
   assign pos_next   = 32'(idx_ff) + 32'd1;
   assign cnt_inc    = 32'(count) + 32'd1;
   assign cnt_dec    = 32'(count) - 32'd1;

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;
      load      = 1'b0;
      cmd.op    = DP_HOLD;
      cmd.value = item.value;
      case (state_ff)
         S_IDLE, S_HOLD: begin
            if ((state_ff == S_IDLE) && accept && !out_free) begin
               held_in  = req_word;
               state_in = S_HOLD;
            end
            if (go) begin
               state_in = S_IDLE;
               rsp_in   = '0;
               rsp_in.is_last = 1'b1;
               case (item.kind)
                  KIND_INSERT: begin
                     load = 1'b1;
                     if (count == CW'(CAPACITY)) begin
                        rsp_in.status      = STATUS_FULL;
                        rsp_in.entry_count = 5'(count);
                     end else begin
                        cmd.op             = DP_INSERT;
                        rsp_in.status      = STATUS_OK;
                        rsp_in.entry_count = cnt_inc[4:0];
                     end
                  end
                  KIND_POP: begin
                     load = 1'b1;
                     if (count == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        cmd.op             = DP_POP;
                        rsp_in.status      = STATUS_OK;
                        rsp_in.entry_value = head;
                        rsp_in.entry_count = cnt_dec[4:0];
                     end
                  end
                  KIND_LIST: begin
                     if (count == '0) begin
                        load          = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         S_LIST: begin
            if (!emitting || out_free) begin
               cmd.op = DP_ROTATE;
               if (emitting) begin
                  load               = 1'b1;
                  rsp_in.status      = STATUS_OK;
                  rsp_in.entry_value = head;
                  rsp_in.position    = pos_next[4:0];
                  rsp_in.entry_count = 5'(count);
                  rsp_in.is_last     = (pos_next == emit_total);
               end
               if (32'(idx_ff) == cnt_dec) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
      held_ff <= held_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Sorted priority queue of up to CAPACITY signed 32-bit values, kept in
// ascending order in a row of registers. Insert and pop each give one
// registered word; back-to-back inserts and pops run at one per cycle while
// the result side keeps up. A list item walks the queue by rotating the row
// once per stored entry, giving one word per entry as the result side allows
// (at most 16 words are emitted; extra entries still rotate through).
// A list of an empty queue gives one word with status empty. A full queue
// drops an insert and reports status full. Kind code 3 is ignored.
module sorted_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output spq_pkg::rsp_word_type rsp_word
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   dp_cmd_type         cmd;
   logic [CW-1:0]      count;
   logic signed [31:0] head;

   spq_control #(
      .CAPACITY (CAPACITY)
   ) u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .cmd       (cmd),
      .count     (count),
      .head      (head)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .count (count),
      .head  (head)
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count) <= 32'(CAPACITY))
      else $error("occupancy above capacity");

   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_INSERT |-> count != CW'(CAPACITY))
      else $error("insert into full queue");

   a_no_shift_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_POP || cmd.op == DP_ROTATE) |-> count != '0)
      else $error("pop or rotate of empty queue");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_INSERT |=> count == $past(count) + CW'(1))
      else $error("insert did not grow occupancy");
`endif

endmodule
